FILE: hdl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg - shared types and constants of the format-spec parser
// Item structs, parser state record, phase and code enums, character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

	// one input character of the replacement-field text
	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
		logic       is_empty;
	} in_item_t;

	// one parse result
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] arg_index;
		logic [1:0]  align_mode;
		logic [7:0]  fill_char;
		logic [1:0]  sign_mode;
		logic        alt_form;
		logic        zero_pad;
		logic        width_given;
		logic [15:0] width;
		logic        prec_given;
		logic [15:0] precision;
		logic [7:0]  type_char;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_ID,
		PH_A0,
		PH_A1,
		PH_SIGN,
		PH_HASH,
		PH_ZERO,
		PH_WIDTH,
		PH_PREC,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK_NOID   = 2'd0,
		ST_OK_ID     = 2'd1,
		ST_BAD_ID    = 2'd2,
		ST_BAD_ALIGN = 2'd3
	} status_t;

	localparam logic [1:0] ALIGN_NONE   = 2'd0;
	localparam logic [1:0] ALIGN_LEFT   = 2'd1;
	localparam logic [1:0] ALIGN_RIGHT  = 2'd2;
	localparam logic [1:0] ALIGN_CENTER = 2'd3;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_MINUS = 2'd2;
	localparam logic [1:0] SIGN_SPACE = 2'd3;

	localparam logic [1:0] SPEC_POS_MAX = 2'd3;

	localparam logic [7:0] CH_LT    = "<";
	localparam logic [7:0] CH_GT    = ">";
	localparam logic [7:0] CH_CARET = "^";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_LOW_P = "p";
	localparam logic [7:0] CH_UP_X  = "X";

	typedef struct packed {
		logic       id_seen;
		logic       bad_id;
		logic       bad_align;
		logic [1:0] align;
		logic [1:0] sign;
		logic       alt;
		logic       zero;
		logic       wgiven;
		logic       pgiven;
	} flags_t;

	// running parser state, all zero after reset and after every result
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  held_char;
		logic [1:0]  spec_pos;
		logic [15:0] id_acc;
		flags_t      flags;
		logic [15:0] width_acc;
		logic [15:0] prec_acc;
		logic [7:0]  fill;
		logic [7:0]  type_ch;
	} spec_state_t;

	localparam spec_state_t SPEC_STATE_RESET = '{
		phase: PH_ID, held_char: 8'd0, spec_pos: 2'd0, id_acc: 16'd0,
		flags: '0, width_acc: 16'd0, prec_acc: 16'd0, fill: 8'd0, type_ch: 8'd0
	};

endpackage

`default_nettype wire

FILE: hdl/fsp_step.sv
// ----------------------------------------------------------------------------
// fsp_step - single-character parser update
// Combinational next state and result for one accepted character or empty-text transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_step (
	input  fsp_pkg::spec_state_t cur,
	input  fsp_pkg::in_item_t    item,
	output fsp_pkg::spec_state_t nxt,
	output logic                 res_valid,
	output fsp_pkg::out_item_t   res
);
	import fsp_pkg::*;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [1:0] align_code(input logic [7:0] c);
		logic [1:0] a;
		case (c)
			CH_LT:    a = ALIGN_LEFT;
			CH_GT:    a = ALIGN_RIGHT;
			CH_CARET: a = ALIGN_CENTER;
			default:  a = ALIGN_NONE;
		endcase
		return a;
	endfunction

	// acc * 10 + digit, saturating at the 16-bit maximum
	function automatic logic [15:0] acc10(input logic [15:0] acc, input logic [7:0] c);
		logic [19:0] v;
		logic [7:0]  d;
		d = c - CH_ZERO;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d[3:0]};
		return (v[19:16] != 4'd0) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic spec_state_t set_type(input spec_state_t s, input logic [7:0] c);
		spec_state_t r;
		r = s;
		r.type_ch = (c == CH_LOW_P) ? CH_UP_X : c;
		r.phase = PH_DONE;
		return r;
	endfunction

	// sign, flag, width, precision and type part of the spec; phases fall through
	function automatic spec_state_t feed_rest(input spec_state_t s, input logic [7:0] c);
		spec_state_t r;
		logic [1:0]  sg;
		logic        used;
		r = s;
		used = 1'b0;
		case (c)
			CH_PLUS:  sg = SIGN_PLUS;
			CH_MINUS: sg = SIGN_MINUS;
			CH_SPACE: sg = SIGN_SPACE;
			default:  sg = SIGN_NONE;
		endcase
		if (r.phase == PH_SIGN) begin
			r.phase = PH_HASH;
			if (sg != SIGN_NONE) begin
				r.flags.sign = r.flags.sign | sg;
				used = 1'b1;
			end
		end
		if (!used && r.phase == PH_HASH) begin
			r.phase = PH_ZERO;
			if (c == CH_HASH) begin
				r.flags.alt = 1'b1;
				used = 1'b1;
			end
		end
		if (!used && r.phase == PH_ZERO) begin
			r.phase = PH_WIDTH;
			if (c == CH_ZERO) begin
				if (r.flags.align == ALIGN_NONE)
					r.flags.zero = 1'b1;
				used = 1'b1;
			end
		end
		if (!used && r.phase == PH_WIDTH) begin
			used = 1'b1;
			if (is_digit(c)) begin
				r.width_acc = acc10(r.width_acc, c);
				r.flags.wgiven = 1'b1;
			end else if (c == CH_DOT) begin
				r.phase = PH_PREC;
			end else begin
				r = set_type(r, c);
			end
		end
		if (!used && r.phase == PH_PREC) begin
			if (is_digit(c)) begin
				r.prec_acc = acc10(r.prec_acc, c);
				r.flags.pgiven = 1'b1;
			end else begin
				r = set_type(r, c);
			end
		end
		return r;
	endfunction

	function automatic spec_state_t take_char(input spec_state_t s, input logic [7:0] c);
		spec_state_t r;
		logic [1:0]  a;
		r = s;
		a = align_code(c);
		case (r.phase)
			PH_ID: begin
				if (c == CH_COLON) begin
					r.phase = PH_A0;
					r.spec_pos = 2'd0;
				end else begin
					r.flags.id_seen = 1'b1;
					if (is_digit(c))
						r.id_acc = acc10(r.id_acc, c);
					else
						r.flags.bad_id = 1'b1;
				end
			end
			PH_A0: begin
				r.spec_pos = 2'd1;
				if (a != ALIGN_NONE) begin
					r.flags.align = r.flags.align | a;
					r.phase = PH_SIGN;
				end else begin
					r.held_char = c;
					r.phase = PH_A1;
				end
			end
			PH_A1: begin
				r.spec_pos = 2'd2;
				r.phase = PH_SIGN;
				if (a != ALIGN_NONE) begin
					r.flags.align = r.flags.align | a;
					r.fill = r.held_char;
					if (r.held_char == CH_LBRACE)
						r.flags.bad_align = 1'b1;
				end else begin
					r = feed_rest(r, r.held_char);
					r = feed_rest(r, c);
				end
			end
			default: begin
				if (a != ALIGN_NONE && r.spec_pos >= 2'd2 && r.flags.align == ALIGN_NONE)
					r.flags.bad_align = 1'b1;
				r = feed_rest(r, c);
				if (r.spec_pos < SPEC_POS_MAX)
					r.spec_pos = r.spec_pos + 2'd1;
			end
		endcase
		return r;
	endfunction

	spec_state_t after_char;
	spec_state_t fin;
	status_t     st;

	always_comb begin
		after_char = item.is_empty ? cur : take_char(cur, item.char_in);
		res_valid  = item.is_empty | item.is_last;

		// a lone pending first spec character resolves at the end of text
		fin = after_char;
		if (fin.phase == PH_A1) begin
			fin.phase = PH_SIGN;
			fin = feed_rest(fin, fin.held_char);
		end

		if (fin.flags.bad_id)
			st = ST_BAD_ID;
		else if (fin.flags.bad_align)
			st = ST_BAD_ALIGN;
		else if (fin.flags.id_seen)
			st = ST_OK_ID;
		else
			st = ST_OK_NOID;

		res = '0;
		res.status = st;
		if (st == ST_OK_ID || st == ST_OK_NOID) begin
			res.arg_index   = (st == ST_OK_ID) ? fin.id_acc : 16'd0;
			res.align_mode  = fin.flags.align;
			res.fill_char   = fin.fill;
			res.sign_mode   = fin.flags.sign;
			res.alt_form    = fin.flags.alt;
			res.zero_pad    = fin.flags.zero;
			res.width_given = fin.flags.wgiven;
			res.width       = fin.width_acc;
			res.prec_given  = fin.flags.pgiven;
			res.precision   = fin.prec_acc;
			res.type_char   = fin.type_ch;
		end

		nxt = res_valid ? SPEC_STATE_RESET : after_char;
	end

endmodule

`default_nettype wire

FILE: hdl/format_spec_parser.sv
// ----------------------------------------------------------------------------
// format_spec_parser - replacement-field format-spec parser
// Parses the text between braces one character per transfer, one result each.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready/in_data) carries one character per transfer;
//    is_last marks the final character, is_empty ends the text without one.
//  - out channel (out_valid/out_ready/out_data) carries one result per text,
//    produced by the transfer that has is_last or is_empty set.
//  - A character transfer lands in the input register; the parser update then
//    runs from there and, for a result, loads the result register.
//    out_valid rises when the result register loads. The parser takes one
//    character per cycle unless a result waits on a stalled receiver.
//  - The per-character update (state record plus a shift-add times ten) is
//    the only logic between the input register and the result/state registers.
//  - Reset clears the parser state and the valid bits of the input register
//    and the result register; the payload registers keep whatever they hold.
//  - When the receiver stalls, the result register holds; a character that
//    yields no result still advances, one that yields a result waits in the
//    input register and in_ready drops until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module format_spec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fsp_pkg::out_item_t  out_data
);
	import fsp_pkg::*;

	// input register
	logic        in_valid_s1;
	in_item_t    in_s1;
	// parser state
	spec_state_t st_q;
	// result register
	logic        out_valid_s2;
	out_item_t   out_s2;

	spec_state_t st_nxt;
	logic        res_valid;
	out_item_t   res;
	logic        advance;

	fsp_step u_step (
		.cur       (st_q),
		.item      (in_s1),
		.nxt       (st_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// advance the held character unless its result has nowhere to go
	assign advance  = in_valid_s1 && (!res_valid || !out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SPEC_STATE_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			// drop once the result is taken
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_s2;

endmodule

`default_nettype wire

FILE: hdl/fsp_checker.sv
// ----------------------------------------------------------------------------
// fsp_checker - port-level checks for format_spec_parser
// Watches the result channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input fsp_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input fsp_pkg::out_item_t out_data
);
	import fsp_pkg::*;

	logic in_seen;
	assign in_seen = in_valid & in_ready & in_data.is_last;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// error results carry zero index, width, precision, type, alignment, fill
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_BAD_ID || out_data.status == ST_BAD_ALIGN)
		|-> out_data.arg_index == 16'd0 && out_data.width == 16'd0 &&
		    out_data.precision == 16'd0 && out_data.type_char == 8'd0 &&
		    out_data.align_mode == ALIGN_NONE && out_data.fill_char == 8'd0)
		else $error("error result with nonzero fields");

	// id only reported with status ok-with-id
	a_id_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK_ID |-> out_data.arg_index == 16'd0)
		else $error("argument index without id status");

	// zero flag dropped under alignment; counts without digits stay zero
	a_flag_consist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.zero_pad && out_data.align_mode != ALIGN_NONE) &&
		    (out_data.width_given || out_data.width == 16'd0) &&
		    (out_data.prec_given || out_data.precision == 16'd0) &&
		    (out_data.align_mode != ALIGN_NONE || out_data.fill_char == 8'd0))
		else $error("inconsistent flag fields");

	// a last character with a free result register gives a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_seen && !out_valid |=> ##1 out_valid)
		else $error("result missing after last character");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

FILE: tb/tb_format_spec_parser.sv
// ----------------------------------------------------------------------------
// tb_format_spec_parser - self-checking bench for the format-spec parser
// Feeds replacement-field texts one character per transfer: a short table of
// hand-picked texts first, then random texts that are mostly well formed
// specs with random content, plus noise and cut-off texts. A model of the
// parser in the bench predicts each result that the table does not give;
// each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_format_spec_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import fsp_pkg::*;

	// stop feeding random texts once this many characters went through
	localparam int N_ITEMS = 2000;
	localparam int N_DIR   = 25;

	// one row of the directed table; st/arg are only used when typed is set
	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        empty;
		logic        typed;
		status_t     st;
		logic [15:0] arg;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;

	// parser model state and the results it predicted, oldest first
	spec_state_t pst = SPEC_STATE_RESET;
	out_item_t   parsed_q [$];

	logic [7:0]  txt [$];
	int          chars_sent = 0;
	int          burst_left = 0;
	int          bad_cnt = 0;

	// receiver stall pattern
	int          rx_mode = 0;
	int          rx_left = 0;
	int          rx_tick = 0;

	// Directed texts. Typed rows carry a result that is plain to see: the
	// empty text, bad ids (byte above 127, NUL), id saturation, a '{' fill,
	// an alignment found too late, and a text closed by the empty flag.
	dir_row_t dir_tab [N_DIR] = '{
		'{8'h5a,    1'b0, 1'b1, 1'b1, ST_OK_NOID,   16'd0},
		'{8'hff,    1'b1, 1'b0, 1'b1, ST_BAD_ID,    16'd0},
		'{8'h00,    1'b1, 1'b0, 1'b1, ST_BAD_ID,    16'd0},
		'{"7",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"0",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"0",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"0",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"0",      1'b1, 1'b0, 1'b1, ST_OK_ID,     16'hffff},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_LBRACE,1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_LT,    1'b1, 1'b0, 1'b1, ST_BAD_ALIGN, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"a",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"b",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_CARET, 1'b1, 1'b0, 1'b1, ST_BAD_ALIGN, 16'd0},
		'{CH_COLON, 1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"*",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_CARET, 1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_SPACE, 1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_ZERO,  1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_DOT,   1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"7",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{CH_LOW_P, 1'b1, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{"1",      1'b0, 1'b0, 1'b0, ST_OK_NOID,   16'd0},
		'{8'h3a,    1'b0, 1'b1, 1'b1, ST_OK_ID,     16'd1}
	};

	format_spec_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic bit is_dec(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// decimal accumulate, clamp at 65535
	function automatic logic [15:0] sat_dec(input logic [15:0] acc, input logic [7:0] c);
		int unsigned v;
		v = 32'(acc) * 10 + 32'(c - CH_ZERO);
		return (v > 65535) ? 16'hffff : v[15:0];
	endfunction

	// Sign, '#', '0', width, '.', precision, type: each stage either takes the
	// character or passes it on to the next stage within the same call.
	function automatic void spec_feed(input logic [7:0] c);
		logic [1:0] s;
		if (pst.phase == PH_SIGN) begin
			case (c)
				CH_PLUS:  s = SIGN_PLUS;
				CH_MINUS: s = SIGN_MINUS;
				CH_SPACE: s = SIGN_SPACE;
				default:  s = SIGN_NONE;
			endcase
			pst.phase = PH_HASH;
			if (s != SIGN_NONE) begin
				pst.flags.sign = s;
				return;
			end
		end
		if (pst.phase == PH_HASH) begin
			pst.phase = PH_ZERO;
			if (c == CH_HASH) begin
				pst.flags.alt = 1'b1;
				return;
			end
		end
		if (pst.phase == PH_ZERO) begin
			pst.phase = PH_WIDTH;
			if (c == CH_ZERO) begin
				// zero padding only counts without an alignment
				if (pst.flags.align == ALIGN_NONE)
					pst.flags.zero = 1'b1;
				return;
			end
		end
		if (pst.phase == PH_WIDTH) begin
			if (is_dec(c)) begin
				pst.width_acc = sat_dec(pst.width_acc, c);
				pst.flags.wgiven = 1'b1;
			end else if (c == CH_DOT) begin
				pst.phase = PH_PREC;
			end else begin
				pst.type_ch = (c == CH_LOW_P) ? CH_UP_X : c;
				pst.phase = PH_DONE;
			end
			return;
		end
		if (pst.phase == PH_PREC) begin
			if (is_dec(c)) begin
				pst.prec_acc = sat_dec(pst.prec_acc, c);
				pst.flags.pgiven = 1'b1;
			end else begin
				pst.type_ch = (c == CH_LOW_P) ? CH_UP_X : c;
				pst.phase = PH_DONE;
			end
		end
	endfunction

	// End of text: settle a pending first spec character, build the result,
	// clear the model state.
	function automatic out_item_t close_text();
		out_item_t r;
		if (pst.phase == PH_A1) begin
			pst.phase = PH_SIGN;
			spec_feed(pst.held_char);
		end
		r = '0;
		if (pst.flags.bad_id)
			r.status = ST_BAD_ID;
		else if (pst.flags.bad_align)
			r.status = ST_BAD_ALIGN;
		else if (pst.flags.id_seen)
			r.status = ST_OK_ID;
		else
			r.status = ST_OK_NOID;
		// error results carry nothing but the status
		if (r.status == ST_OK_ID || r.status == ST_OK_NOID) begin
			r.arg_index   = (r.status == ST_OK_ID) ? pst.id_acc : 16'd0;
			r.align_mode  = pst.flags.align;
			r.fill_char   = pst.fill;
			r.sign_mode   = pst.flags.sign;
			r.alt_form    = pst.flags.alt;
			r.zero_pad    = pst.flags.zero;
			r.width_given = pst.flags.wgiven;
			r.width       = pst.width_acc;
			r.prec_given  = pst.flags.pgiven;
			r.precision   = pst.prec_acc;
			r.type_char   = pst.type_ch;
		end
		pst = SPEC_STATE_RESET;
		return r;
	endfunction

	// Advance the model by one transfer; return 1 with the result when the
	// transfer ends the text.
	function automatic bit parse_char(input in_item_t it, output out_item_t res);
		logic [7:0] c;
		logic [1:0] a;
		res = '0;
		if (it.is_empty) begin
			res = close_text();
			return 1'b1;
		end
		c = it.char_in;
		case (c)
			CH_LT:    a = ALIGN_LEFT;
			CH_GT:    a = ALIGN_RIGHT;
			CH_CARET: a = ALIGN_CENTER;
			default:  a = ALIGN_NONE;
		endcase
		case (pst.phase)
			PH_ID: begin
				if (c == CH_COLON) begin
					pst.phase = PH_A0;
					pst.spec_pos = 2'd0;
				end else begin
					pst.flags.id_seen = 1'b1;
					if (is_dec(c))
						pst.id_acc = sat_dec(pst.id_acc, c);
					else
						pst.flags.bad_id = 1'b1;
				end
			end
			PH_A0: begin
				pst.spec_pos = 2'd1;
				if (a != ALIGN_NONE) begin
					pst.flags.align = a;
					pst.phase = PH_SIGN;
				end else begin
					// hold it: fill if an alignment follows, else fed to the spec stages
					pst.held_char = c;
					pst.phase = PH_A1;
				end
			end
			PH_A1: begin
				pst.spec_pos = 2'd2;
				pst.phase = PH_SIGN;
				if (a != ALIGN_NONE) begin
					pst.flags.align = a;
					pst.fill = pst.held_char;
					if (pst.held_char == CH_LBRACE)
						pst.flags.bad_align = 1'b1;
				end else begin
					spec_feed(pst.held_char);
					spec_feed(c);
				end
			end
			default: begin
				// an alignment character past the fill slot is an error if none was given
				if (a != ALIGN_NONE && pst.spec_pos >= 2'd2 && pst.flags.align == ALIGN_NONE)
					pst.flags.bad_align = 1'b1;
				spec_feed(c);
				if (pst.spec_pos < SPEC_POS_MAX)
					pst.spec_pos = pst.spec_pos + 2'd1;
			end
		endcase
		if (it.is_last) begin
			res = close_text();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic out_item_t bare_result(input status_t st, input logic [15:0] arg);
		out_item_t r;
		r = '0;
		r.status = st;
		r.arg_index = arg;
		return r;
	endfunction

	function automatic string fmt_result(input out_item_t r);
		return $sformatf({"st=%0d id=%0d al=%0d fill=%02h sg=%0d alt=%0b zp=%0b ",
			"wg=%0b w=%0d pg=%0b p=%0d ty=%02h"},
			r.status, r.arg_index, r.align_mode, r.fill_char, r.sign_mode,
			r.alt_form, r.zero_pad, r.width_given, r.width, r.prec_given,
			r.precision, r.type_char);
	endfunction

	// ------------------------------------------------------------------
	// Random texts
	// ------------------------------------------------------------------

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_align();
		case ($urandom_range(0, 2))
			0:       return CH_LT;
			1:       return CH_GT;
			default: return CH_CARET;
		endcase
	endfunction

	// Fill txt with one text: mostly well formed specs with random content,
	// some pure noise, some with a bad id character, some cut short.
	task automatic compose_text();
		int unsigned kind;
		int unsigned n;
		logic [7:0]  c;
		txt.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(0, 10);
			repeat (n) txt.push_back(8'($urandom_range(0, 255)));
		end else begin
			// argument id: none, short, long enough that it may saturate
			case ($urandom_range(0, 4))
				0:       n = 0;
				3:       n = $urandom_range(5, 7);
				default: n = $urandom_range(1, 3);
			endcase
			repeat (n) txt.push_back(rand_digit());
			if (kind == 1 && txt.size() != 0)
				txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 5) != 0) begin
				txt.push_back(CH_COLON);
				case ($urandom_range(0, 3))
					1: txt.push_back(rand_align());
					2: begin
						c = ($urandom_range(0, 7) == 0) ? CH_LBRACE : 8'($urandom_range(0, 255));
						txt.push_back(c);
						txt.push_back(rand_align());
					end
					3: txt.push_back(8'($urandom_range(32, 126)));
					default: ;
				endcase
				case ($urandom_range(0, 3))
					1: txt.push_back(CH_PLUS);
					2: txt.push_back(CH_MINUS);
					3: txt.push_back(CH_SPACE);
					default: ;
				endcase
				if ($urandom_range(0, 1))
					txt.push_back(CH_HASH);
				if ($urandom_range(0, 1))
					txt.push_back(CH_ZERO);
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
				repeat (n) txt.push_back(rand_digit());
				if ($urandom_range(0, 2) == 0) begin
					txt.push_back(CH_DOT);
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
					repeat (n) txt.push_back(rand_digit());
				end
				if ($urandom_range(0, 4) != 0) begin
					case ($urandom_range(0, 9))
						0: c = "d";
						1: c = "x";
						2: c = CH_UP_X;
						3: c = "b";
						4: c = "B";
						5: c = "o";
						6: c = CH_LOW_P;
						7: c = "s";
						default: c = 8'($urandom_range(0, 255));
					endcase
					txt.push_back(c);
				end
				// trailing characters after the type, alignment marks among them
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 3))
							0:       txt.push_back(rand_align());
							1:       txt.push_back(rand_digit());
							2:       txt.push_back(CH_COLON);
							default: txt.push_back(8'($urandom_range(0, 255)));
						endcase
					end
				end
			end
			if (kind == 2 && txt.size() > 1) begin
				n = $urandom_range(1, txt.size() - 1);
				while (txt.size() > n)
					void'(txt.pop_back());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Present one character, hold it until the transfer, then predict. Valid
	// stays high into the next call unless a gap closes the burst here.
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t res;
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (parse_char(it, res))
			parsed_q.push_back(typed ? typed_res : res);
		chars_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end
		end
	endtask

	initial begin
		in_item_t it;
		bit       by_empty;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int i = 0; i < N_DIR; i++) begin
			it = '{char_in: dir_tab[i].ch, is_last: dir_tab[i].last, is_empty: dir_tab[i].empty};
			send_item(it, dir_tab[i].typed, bare_result(dir_tab[i].st, dir_tab[i].arg));
		end

		// random texts, closed by the last character or by an empty-flag transfer
		while (chars_sent < N_ITEMS) begin
			compose_text();
			by_empty = (txt.size() == 0) || ($urandom_range(0, 6) == 0);
			foreach (txt[k]) begin
				it = '{char_in: txt[k], is_last: !by_empty && (k == txt.size() - 1),
					is_empty: 1'b0};
				send_item(it, 1'b0, '0);
			end
			if (by_empty) begin
				it = '{char_in: 8'($urandom_range(0, 255)), is_last: 1'($urandom_range(0, 1)),
					is_empty: 1'b1};
				send_item(it, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// drain, then give any stray result time to show up
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (bad_cnt == 0)
			$display("[format_spec_parser] OK");
		else
			$display("[format_spec_parser] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: check each result transfer, then pick out_ready for the next
	// cycle from a stall mode that is itself picked at random.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t w;
		if (out_valid && out_ready) begin
			if (parsed_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected result: %s", fmt_result(out_data));
			end else begin
				w = parsed_q.pop_front();
				if (out_data.status !== w.status || out_data.arg_index !== w.arg_index ||
					out_data.align_mode !== w.align_mode ||
					out_data.fill_char !== w.fill_char ||
					out_data.sign_mode !== w.sign_mode || out_data.alt_form !== w.alt_form ||
					out_data.zero_pad !== w.zero_pad ||
					out_data.width_given !== w.width_given || out_data.width !== w.width ||
					out_data.prec_given !== w.prec_given ||
					out_data.precision !== w.precision ||
					out_data.type_char !== w.type_char) begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected: %s", fmt_result(w));
						$display("  actual:   %s", fmt_result(out_data));
					end
				end
			end
		end

		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			2:       out_ready <= (rx_tick % 4 == 0);
			default: out_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Watchdog: the slowest correct run is well under a tenth of this.
	initial begin
		#5_000_000;
		$display("[format_spec_parser] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
